>>> hw/rtl/asn_pkg.sv
// ---------------------------------------------------------------------------
// asn_pkg: shared types and constants of the autorange sensor to note unit
// Sample width, divider widths, the job passed from front to back and the
// completion status passed back.
// ---------------------------------------------------------------------------
`default_nettype none

package asn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;   // sample minus range low, never negative
  localparam int NOTE_BITS   = 7;
  localparam int DIV_BITS    = DIFF_BITS + NOTE_BITS;
  localparam int TICK_BITS   = 16;
  localparam int GAP_BITS    = 16;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [NOTE_BITS-1:0] NOTE_TOP      = 7'd127;
  localparam logic [NOTE_BITS-1:0] KEY_PLAY_LOW  = 7'd2;
  localparam logic [NOTE_BITS-1:0] KEY_PLAY_HIGH = 7'd125;

  localparam logic [1:0] REG_MIN_GAP    = 2'd0;
  localparam logic [1:0] REG_KEY_INVERT = 2'd1;
  localparam logic [1:0] REG_VEL_INVERT = 2'd2;

  localparam logic ACTION_OFF  = 1'b0;
  localparam logic ACTION_PLAY = 1'b1;

  typedef struct packed {
    logic [DIFF_BITS-1:0] key_num;
    logic [DIFF_BITS-1:0] key_span;
    logic [DIFF_BITS-1:0] vel_num;
    logic [DIFF_BITS-1:0] vel_span;
  } job_t;

  typedef struct packed {
    logic done;
    logic play;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/asn_front.sv
// ---------------------------------------------------------------------------
// asn_front: tick intake and range tracking
// Applies the clear flags, counts ticks since the last play, widens the
// ranges and hands span and offset of both channels to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module asn_front
  import asn_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [SAMPLE_BITS-1:0] key_sample,
  input  wire  signed [SAMPLE_BITS-1:0] vel_sample,
  input  wire                          clear_key_range,
  input  wire                          clear_vel_range,
  input  wire         [GAP_BITS-1:0]   min_gap,
  output logic                         job_valid,
  input  wire                          job_ready,
  output job_t                         job,
  input  status_t                      status
);

  logic signed [SAMPLE_BITS-1:0] key_low, key_high, vel_low, vel_high;
  logic [TICK_BITS-1:0] ticks;
  logic busy;

  logic signed [SAMPLE_BITS-1:0] kl_c, kh_c, vl_c, vh_c;
  logic signed [SAMPLE_BITS-1:0] kl_next, kh_next, vl_next, vh_next;
  logic [TICK_BITS-1:0] ticks_inc;
  logic evaluate;
  logic accept;

  assign in_ready = !busy && job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    kl_c = clear_key_range ? SAMPLE_MAX : key_low;
    kh_c = clear_key_range ? SAMPLE_MIN : key_high;
    vl_c = clear_vel_range ? SAMPLE_MAX : vel_low;
    vh_c = clear_vel_range ? SAMPLE_MIN : vel_high;
    ticks_inc = (ticks == {TICK_BITS{1'b1}}) ? ticks : ticks + 1'b1;
    evaluate  = ticks_inc > min_gap;
    kl_next = kl_c;
    kh_next = kh_c;
    vl_next = vl_c;
    vh_next = vh_c;
    if (evaluate) begin
      if (key_sample > kh_c) kh_next = key_sample;
      if (key_sample < kl_c) kl_next = key_sample;
      if (vel_sample > vh_c) vh_next = vel_sample;
      if (vel_sample < vl_c) vl_next = vel_sample;
    end
  end

  // Offsets and spans are taken after widening, so none of them is negative.
  always_comb begin
    job.key_num  = DIFF_BITS'($signed({key_sample[SAMPLE_BITS-1], key_sample})
                              - $signed({kl_next[SAMPLE_BITS-1], kl_next}));
    job.key_span = DIFF_BITS'($signed({kh_next[SAMPLE_BITS-1], kh_next})
                              - $signed({kl_next[SAMPLE_BITS-1], kl_next}));
    job.vel_num  = DIFF_BITS'($signed({vel_sample[SAMPLE_BITS-1], vel_sample})
                              - $signed({vl_next[SAMPLE_BITS-1], vl_next}));
    job.vel_span = DIFF_BITS'($signed({vh_next[SAMPLE_BITS-1], vh_next})
                              - $signed({vl_next[SAMPLE_BITS-1], vl_next}));
  end

  assign job_valid = accept && evaluate;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= SAMPLE_MAX;
      key_high <= SAMPLE_MIN;
      vel_low  <= SAMPLE_MAX;
      vel_high <= SAMPLE_MIN;
      ticks    <= {TICK_BITS{1'b1}};
      busy     <= 1'b0;
    end else begin
      if (accept) begin
        key_low  <= kl_next;
        key_high <= kh_next;
        vel_low  <= vl_next;
        vel_high <= vh_next;
        ticks    <= ticks_inc;
        busy     <= evaluate;
      end else if (status.done) begin
        busy <= 1'b0;
        if (status.play) begin
          ticks <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/asn_queue.sv
// ---------------------------------------------------------------------------
// asn_queue: two-entry job queue
// Decouples the intake from the divider back end.
// ---------------------------------------------------------------------------
`default_nettype none

module asn_queue
  import asn_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   push_valid,
  output logic  push_ready,
  input  job_t  push_job,
  output logic  pop_valid,
  input  wire   pop_ready,
  output job_t  pop_job
);

  job_t       entry [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/asn_back.sv
// ---------------------------------------------------------------------------
// asn_back: scaling divider and note decision
// One restoring divider, shared by key and velocity, yields seven quotient
// bits per channel; the note decision goes into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module asn_back
  import asn_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  job_valid,
  output logic                 job_ready,
  input  job_t                 job,
  input  wire                  key_invert,
  input  wire                  vel_invert,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_action,
  output logic [NOTE_BITS-1:0] out_key,
  output logic [NOTE_BITS-1:0] out_vel,
  output status_t              status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam logic [2:0] LAST_STEP = 3'(NOTE_BITS - 1);

  logic [1:0] state;
  logic [2:0] step;
  logic       chan;          // 0 key, 1 velocity
  job_t       cur;
  logic [DIV_BITS-1:0]  rem;
  logic [NOTE_BITS-1:0] quo, key_q;

  logic [DIFF_BITS-1:0] span;
  logic [DIV_BITS-1:0]  trial;
  logic                 fits;
  logic [NOTE_BITS-1:0] quo_next, quo_fix;
  logic [NOTE_BITS-1:0] key_m, vel_m;
  logic                 play;
  logic                 deliver;

  function automatic logic [DIV_BITS-1:0] times_top(input logic [DIFF_BITS-1:0] n);
    times_top = {n, {NOTE_BITS{1'b0}}} - DIV_BITS'(n);
  endfunction

  always_comb begin
    span     = chan ? cur.vel_span : cur.key_span;
    trial    = DIV_BITS'(span) << (LAST_STEP - step);
    fits     = rem >= trial;
    quo_next = {quo[NOTE_BITS-2:0], fits};
    // A zero span scales to zero.
    quo_fix  = (span == '0) ? '0 : quo_next;
  end

  always_comb begin
    key_m   = key_invert ? NOTE_TOP - key_q : key_q;
    vel_m   = vel_invert ? NOTE_TOP - quo : quo;
    play    = key_m >= KEY_PLAY_LOW && key_m <= KEY_PLAY_HIGH;
    deliver = (state == ST_OUT) && (!out_valid || out_ready);
  end

  assign job_ready   = state == ST_IDLE;
  assign status.done = deliver;
  assign status.play = play;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (job_valid) state <= ST_DIV;
        ST_DIV:  if (chan && step == LAST_STEP) state <= ST_OUT;
        ST_OUT:  if (deliver) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur  <= job;
        rem  <= times_top(job.key_num);
        quo  <= '0;
        step <= '0;
        chan <= 1'b0;
      end
      ST_DIV: begin
        if (step == LAST_STEP) begin
          step <= '0;
          if (!chan) begin
            key_q <= quo_fix;
            chan  <= 1'b1;
            rem   <= times_top(cur.vel_num);
            quo   <= '0;
          end else begin
            quo <= quo_fix;
          end
        end else begin
          if (fits) rem <= rem - trial;
          quo  <= quo_next;
          step <= step + 3'd1;
        end
      end
      ST_OUT: begin
        if (deliver) begin
          out_action <= play ? ACTION_PLAY : ACTION_OFF;
          out_key    <= play ? key_m : '0;
          out_vel    <= play ? vel_m : '0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/autorange_sensor_to_note_unit.sv
// ---------------------------------------------------------------------------
// autorange_sensor_to_note_unit: autoranging sensor to note trigger
// Tracks adaptive ranges of a key and a velocity channel and turns each
// millisecond tick into an optional note-on or note-off.
// ---------------------------------------------------------------------------
//  channel  direction  transaction
//  s_*      in         one tick: key and velocity samples, range clear flags
//  m_*      out        one note event: action, key number, velocity
//  cfg_*    in         register write: min_gap, key_invert, vel_invert
//
// A tick that does not reach the gap gives no event and leaves the intake free.
// An evaluated tick runs two channels of seven restoring divider steps each,
// one after the other on the one shared divider, plus the output hand-over.
// The next tick is taken once the note decision has gone to the output
// register, which may still be waiting on m_tready.
// Reset is synchronous; it empties the ranges and saturates the tick count.
// ---------------------------------------------------------------------------
`default_nettype none

module autorange_sensor_to_note_unit
  import asn_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,     // key_sample[15:0], vel_sample[31:16]
  input  wire  [1:0]  s_tuser,     // clear_key_range[0], clear_vel_range[1]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,     // note_key[6:0], note_velocity[13:7], zeros[15:14]
  output logic        m_tuser,     // action[0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  logic [GAP_BITS-1:0] min_gap;
  logic key_invert, vel_invert;

  job_t    front_job, back_job;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  status_t status;
  logic [NOTE_BITS-1:0] out_key, out_vel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap    <= GAP_BITS'(40);
      key_invert <= 1'b0;
      vel_invert <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_GAP:    min_gap    <= cfg_data[GAP_BITS-1:0];
        REG_KEY_INVERT: key_invert <= cfg_data[0];
        REG_VEL_INVERT: vel_invert <= cfg_data[0];
        default: ;
      endcase
    end
  end

  asn_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .key_sample      (s_tdata[15:0]),
    .vel_sample      (s_tdata[31:16]),
    .clear_key_range (s_tuser[0]),
    .clear_vel_range (s_tuser[1]),
    .min_gap         (min_gap),
    .job_valid       (push_valid),
    .job_ready       (push_ready),
    .job             (front_job),
    .status          (status)
  );

  asn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (front_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (back_job)
  );

  asn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job        (back_job),
    .key_invert (key_invert),
    .vel_invert (vel_invert),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_action (m_tuser),
    .out_key    (out_key),
    .out_vel    (out_vel),
    .status     (status)
  );

  assign m_tdata = {2'b00, out_vel, out_key};

  // The back end only finishes an item that the front end is waiting on.
  assert property (@(posedge clk) disable iff (rst) status.done |-> !s_tready)
    else $error("completion without a pending tick");

  // A job is never pushed into a full queue.
  assert property (@(posedge clk) disable iff (rst) push_valid |-> push_ready)
    else $error("job pushed into full queue");

  // A play always carries a key inside the playable band.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ACTION_PLAY) |->
      (m_tdata[6:0] >= KEY_PLAY_LOW && m_tdata[6:0] <= KEY_PLAY_HIGH))
    else $error("play outside key band");

  // A note-off carries zero key and velocity.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ACTION_OFF) |-> m_tdata == 16'd0)
    else $error("note-off with nonzero payload");

endmodule

`default_nettype wire
